// ===== hw/rtl/bba_pkg.sv =====
// Package for the buddy block allocator.
// Holds the controller states, datapath commands, status codes and the status struct.
// Depends on nothing.
package bba_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RB_INIT,
        S_RB_CHECK,
        S_RB_P1,
        S_RB_P2,
        S_CHECK,
        S_AL_SCAN,
        S_AL_POP1,
        S_AL_POP2,
        S_AL_SPLIT,
        S_AL_P1,
        S_AL_P2,
        S_FR_LOOP,
        S_FR_WALK,
        S_FR_WAIT,
        S_FR_UL1,
        S_FR_UL2,
        S_FR_P1,
        S_FR_P2,
        S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        C_NONE,
        C_LOAD,
        C_BADORDER,
        C_RB_INIT,
        C_RB_SETUP,
        C_PUSH1,
        C_PUSH2,
        C_PUSH2_RB,
        C_AL_SCAN,
        C_AL_POP1,
        C_AL_POP2,
        C_AL_SETUP,
        C_FR_LOOP,
        C_FR_WALK,
        C_FR_WAIT,
        C_FR_UL1,
        C_FR_UL2
    } cmd_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
    localparam logic [1:0] STATUS_BAD_ORDER = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic bad_order;
        logic is_free;
        logic free_ok;
        logic rem_zero;
        logic head_valid;
        logic cur_at_top;
        logic split_done;
        logic walk_end;
        logic walk_hit;
    } dp_status_t;

endpackage

// ===== hw/rtl/bba_datapath.sv =====
// Datapath of the buddy block allocator: list heads, link memories and working registers.
// Executes one command from the controller per cycle; depends on bba_pkg.
module bba_datapath #(
    parameter int MAX_BLOCKS = 1024,
    parameter int MAX_ORDER  = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bba_pkg::cmd_t       cmd,
    input  logic                cfg_we,
    input  logic [10:0]         cfg_data,
    input  logic                mode,
    input  logic [3:0]          order,
    input  logic [9:0]          block_index,
    output bba_pkg::dp_status_t sts,
    output logic [1:0]          status,
    output logic [9:0]          granted_index
);
    import bba_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = IW + 1;
    localparam int AW = (LW > 11) ? LW : 11;
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int CW = (OW > 4) ? OW : 4;
    localparam int RESET_BLOCKS = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;
    localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);
    localparam logic [AW-1:0] MAXV = AW'(MAX_BLOCKS);

    logic [LW-1:0] next_mem [MAX_BLOCKS];
    logic [LW-1:0] prev_mem [MAX_BLOCKS];

    logic [AW-1:0] usable_reg;
    logic [OW-1:0] top_reg;
    logic [LW-1:0] head_reg [MAX_ORDER+1];
    logic [OW-1:0] cur_reg;
    logic [CW-1:0] req_reg;
    logic          mode_reg;
    logic [AW-1:0] blk_reg;
    logic [AW-1:0] base_reg;
    logic [AW-1:0] rem_reg;
    logic [AW-1:0] pblk_reg;
    logic [LW-1:0] b_reg;
    logic [LW-1:0] p_reg;
    logic [AW-1:0] buddy_reg;
    logic [LW-1:0] steps_reg;
    logic [1:0]    status_reg;
    logic [LW-1:0] granted_reg;
    logic [LW-1:0] next_rd_reg;
    logic [LW-1:0] prev_rd_reg;

    logic          next_we;
    logic [IW-1:0] next_wa;
    logic [LW-1:0] next_wd;
    logic          prev_we;
    logic [IW-1:0] prev_wa;
    logic [LW-1:0] prev_wd;
    logic [IW-1:0] next_ra;
    logic [IW-1:0] prev_ra;

    logic [LW-1:0] head_cur;
    logic          head_valid;
    logic [AW-1:0] bit_cur;
    logic [OW-1:0] cur_dec;
    logic [OW-1:0] rb_k;
    logic [OW-1:0] rem_log;
    logic          pblk_ok;
    logic          walk_end;
    logic [AW-1:0] cfg_value;
    logic [AW-1:0] cfg_clamped;

    function automatic logic [OW-1:0] flog(input logic [AW-1:0] v);
        int r;
        r = 0;
        for (int i = 0; i < AW; i++)
        begin
            if (v[i])
            begin
                r = i;
            end
        end
        if (r > MAX_ORDER)
        begin
            r = MAX_ORDER;
        end
        return OW'(r);
    endfunction

    assign head_cur   = head_reg[cur_reg];
    assign head_valid = head_cur < NIL;
    assign bit_cur    = AW'(1) << cur_reg;
    assign cur_dec    = cur_reg - OW'(1);
    assign rem_log    = flog(rem_reg);
    assign rb_k       = (rem_log > top_reg) ? top_reg : rem_log;
    assign pblk_ok    = pblk_reg < MAXV;
    assign walk_end   = (p_reg >= NIL) || (steps_reg == NIL);
    assign cfg_value  = AW'(cfg_data);

    always_comb
    begin
        cfg_clamped = cfg_value;
        if (cfg_value == '0)
        begin
            cfg_clamped = AW'(1);
        end
        else if (cfg_value > MAXV)
        begin
            cfg_clamped = MAXV;
        end
    end

    always_comb
    begin
        sts.bad_order  = req_reg > CW'(top_reg);
        sts.is_free    = mode_reg == MODE_FREE;
        sts.free_ok    = ((blk_reg & (bit_cur - AW'(1))) == '0) &&
                         (({1'b0, blk_reg} + {1'b0, bit_cur}) <= {1'b0, usable_reg});
        sts.rem_zero   = rem_reg == '0;
        sts.head_valid = head_valid;
        sts.cur_at_top = cur_reg == top_reg;
        sts.split_done = CW'(cur_reg) == req_reg;
        sts.walk_end   = walk_end;
        sts.walk_hit   = !walk_end && (AW'(p_reg) == buddy_reg);
    end

    always_comb
    begin
        next_we = 1'b0;
        next_wa = '0;
        next_wd = NIL;
        prev_we = 1'b0;
        prev_wa = '0;
        prev_wd = NIL;
        next_ra = head_cur[IW-1:0];
        prev_ra = p_reg[IW-1:0];
        case (cmd)
            C_PUSH1:
            begin
                prev_we = pblk_ok && head_valid;
                prev_wa = head_cur[IW-1:0];
                prev_wd = LW'(pblk_reg);
            end
            C_PUSH2, C_PUSH2_RB:
            begin
                next_we = pblk_ok;
                next_wa = pblk_reg[IW-1:0];
                next_wd = head_cur;
                prev_we = pblk_ok;
                prev_wa = pblk_reg[IW-1:0];
                prev_wd = NIL;
            end
            C_AL_POP1:
            begin
                prev_we = next_rd_reg < NIL;
                prev_wa = next_rd_reg[IW-1:0];
                prev_wd = NIL;
                next_we = 1'b1;
                next_wa = b_reg[IW-1:0];
                next_wd = NIL;
            end
            C_AL_POP2:
            begin
                prev_we = 1'b1;
                prev_wa = b_reg[IW-1:0];
                prev_wd = NIL;
            end
            C_FR_WALK:
            begin
                next_ra = p_reg[IW-1:0];
            end
            C_FR_UL1:
            begin
                prev_we = next_rd_reg < NIL;
                prev_wa = next_rd_reg[IW-1:0];
                prev_wd = prev_rd_reg;
                next_we = prev_rd_reg < NIL;
                next_wa = prev_rd_reg[IW-1:0];
                next_wd = next_rd_reg;
            end
            C_FR_UL2:
            begin
                next_we = 1'b1;
                next_wa = p_reg[IW-1:0];
                next_wd = NIL;
                prev_we = 1'b1;
                prev_wa = p_reg[IW-1:0];
                prev_wd = NIL;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        next_rd_reg <= next_mem[next_ra];
        prev_rd_reg <= prev_mem[prev_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usable_reg <= AW'(RESET_BLOCKS);
        end
        else if (cfg_we)
        begin
            usable_reg <= cfg_clamped;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            C_LOAD:
            begin
                mode_reg    <= mode;
                req_reg     <= CW'(order);
                cur_reg     <= OW'(order);
                blk_reg     <= AW'(block_index);
                status_reg  <= STATUS_OK;
                granted_reg <= '0;
            end
            C_BADORDER:
            begin
                status_reg <= STATUS_BAD_ORDER;
            end
            C_RB_INIT:
            begin
                for (int i = 0; i <= MAX_ORDER; i++)
                begin
                    head_reg[i] <= NIL;
                end
                top_reg  <= flog(usable_reg);
                base_reg <= '0;
                rem_reg  <= usable_reg;
            end
            C_RB_SETUP:
            begin
                cur_reg  <= rb_k;
                pblk_reg <= base_reg;
            end
            C_PUSH2, C_PUSH2_RB:
            begin
                if (pblk_ok)
                begin
                    head_reg[cur_reg] <= LW'(pblk_reg);
                end
                if (cmd == C_PUSH2_RB)
                begin
                    base_reg <= base_reg + bit_cur;
                    rem_reg  <= rem_reg - bit_cur;
                end
            end
            C_AL_SCAN:
            begin
                if (head_valid)
                begin
                    b_reg <= head_cur;
                end
                else if (cur_reg != top_reg)
                begin
                    cur_reg <= cur_reg + OW'(1);
                end
                else
                begin
                    status_reg <= STATUS_NO_FREE;
                end
            end
            C_AL_POP1:
            begin
                head_reg[cur_reg] <= next_rd_reg;
            end
            C_AL_POP2:
            begin
                granted_reg <= b_reg;
            end
            C_AL_SETUP:
            begin
                cur_reg  <= cur_dec;
                pblk_reg <= AW'(b_reg) + (AW'(1) << cur_dec);
            end
            C_FR_LOOP:
            begin
                buddy_reg <= blk_reg ^ bit_cur;
                p_reg     <= head_cur;
                steps_reg <= '0;
                pblk_reg  <= blk_reg;
            end
            C_FR_WALK:
            begin
                steps_reg <= steps_reg + LW'(1);
            end
            C_FR_WAIT:
            begin
                p_reg <= next_rd_reg;
            end
            C_FR_UL1:
            begin
                if (prev_rd_reg >= NIL)
                begin
                    head_reg[cur_reg] <= next_rd_reg;
                end
            end
            C_FR_UL2:
            begin
                blk_reg <= blk_reg & ~bit_cur;
                cur_reg <= cur_reg + OW'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign status        = status_reg;
    assign granted_index = 10'(granted_reg);

endmodule

// ===== hw/rtl/bba_controller.sv =====
// Controller state machine of the buddy block allocator.
// Sequences rebuild, allocate and free commands to the datapath; depends on bba_pkg.
module bba_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cfg_we,
    input  bba_pkg::dp_status_t sts,
    output bba_pkg::cmd_t       cmd,
    output logic                busy,
    output logic                done
);
    import bba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RB_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = C_NONE;
        busy       = state_reg != S_IDLE;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = S_RB_INIT;
                end
                else if (start)
                begin
                    cmd        = C_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_RB_INIT:
            begin
                cmd        = C_RB_INIT;
                state_next = S_RB_CHECK;
            end
            S_RB_CHECK:
            begin
                cmd        = C_RB_SETUP;
                state_next = sts.rem_zero ? S_IDLE : S_RB_P1;
            end
            S_RB_P1:
            begin
                cmd        = C_PUSH1;
                state_next = S_RB_P2;
            end
            S_RB_P2:
            begin
                cmd        = C_PUSH2_RB;
                state_next = S_RB_CHECK;
            end
            S_CHECK:
            begin
                if (sts.bad_order)
                begin
                    cmd        = C_BADORDER;
                    state_next = S_FINISH;
                end
                else if (!sts.is_free)
                begin
                    state_next = S_AL_SCAN;
                end
                else if (sts.free_ok)
                begin
                    state_next = S_FR_LOOP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_AL_SCAN:
            begin
                cmd = C_AL_SCAN;
                if (sts.head_valid)
                begin
                    state_next = S_AL_POP1;
                end
                else if (sts.cur_at_top)
                begin
                    state_next = S_FINISH;
                end
            end
            S_AL_POP1:
            begin
                cmd        = C_AL_POP1;
                state_next = S_AL_POP2;
            end
            S_AL_POP2:
            begin
                cmd        = C_AL_POP2;
                state_next = S_AL_SPLIT;
            end
            S_AL_SPLIT:
            begin
                cmd        = C_AL_SETUP;
                state_next = sts.split_done ? S_FINISH : S_AL_P1;
            end
            S_AL_P1:
            begin
                cmd        = C_PUSH1;
                state_next = S_AL_P2;
            end
            S_AL_P2:
            begin
                cmd        = C_PUSH2;
                state_next = S_AL_SPLIT;
            end
            S_FR_LOOP:
            begin
                cmd        = C_FR_LOOP;
                state_next = sts.cur_at_top ? S_FR_P1 : S_FR_WALK;
            end
            S_FR_WALK:
            begin
                cmd = C_FR_WALK;
                if (sts.walk_end)
                begin
                    state_next = S_FR_P1;
                end
                else if (sts.walk_hit)
                begin
                    state_next = S_FR_UL1;
                end
                else
                begin
                    state_next = S_FR_WAIT;
                end
            end
            S_FR_WAIT:
            begin
                cmd        = C_FR_WAIT;
                state_next = S_FR_WALK;
            end
            S_FR_UL1:
            begin
                cmd        = C_FR_UL1;
                state_next = S_FR_UL2;
            end
            S_FR_UL2:
            begin
                cmd        = C_FR_UL2;
                state_next = S_FR_LOOP;
            end
            S_FR_P1:
            begin
                cmd        = C_PUSH1;
                state_next = S_FR_P2;
            end
            S_FR_P2:
            begin
                cmd        = C_PUSH2;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/buddy_block_allocator_core.sv =====
// Top level of the buddy block allocator.
// Joins bba_controller and bba_datapath; depends on bba_pkg.
//
// An item is taken when start is high while busy and cfg_we are low: mode selects
// allocate or free, order gives the size as a power of two and block_index the
// region freed. Exactly one result follows per item; done is high for one cycle
// with status and granted_index, and the receiver cannot stall it.
// An allocate scans upward past empty orders, pops the first free block it finds
// and halves it down to the requested order, pushing each upper half on its list.
// A free walks the free list of its order in search of the buddy; when found, the
// buddy is unlinked and the two merge into a block one order up, where the walk
// starts again. Each walked entry passes through S_FR_WALK and S_FR_WAIT because
// the link memories are read through a register.
// A rejected order or an ill-formed free goes from S_CHECK straight to S_FINISH.
// After reset, and after each write of cfg_data with cfg_we while idle, the free
// lists are rebuilt from the usable block count; busy stays high meanwhile.
// The memories need no clearing pass.
module buddy_block_allocator_core #(
    parameter int MAX_BLOCKS = 1024,
    parameter int MAX_ORDER  = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [3:0]  order,
    input  logic [9:0]  block_index,
    output logic        done,
    output logic [1:0]  status,
    output logic [9:0]  granted_index,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data
);
    import bba_pkg::*;

    cmd_t       cmd;
    dp_status_t sts;

    bba_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_we (cfg_we),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_ORDER  (MAX_ORDER)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .order         (order),
        .block_index   (block_index),
        .sts           (sts),
        .status        (status),
        .granted_index (granted_index)
    );

endmodule

// ===== hw/rtl/bba_checker.sv =====
// Port-level checks for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator_core.
module bba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [9:0]  granted_index,
    input logic        cfg_we
);
    import bba_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("Accepted item did not make the block busy.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("Block not idle after a result.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STATUS_OK || status == STATUS_NO_FREE ||
                  status == STATUS_BAD_ORDER))
        else $error("Result carries an undefined status.");

    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STATUS_OK |-> granted_index == '0)
        else $error("Failed item carries a non-zero granted index.");

    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && !busy |=> busy)
        else $error("Register write did not start a rebuild.");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);
